@@ rtl/core/assert_macros.svh @@
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/core/scfs_pkg.sv @@
// ---------------------------------------------------------------------------
// scfs_pkg
// shared types, codes and tables of the sound channel frame sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package scfs_pkg;
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [4:0] A_P1_CTL = 5'h00;
  localparam logic [4:0] A_P2_HI  = 5'h07;
  localparam logic [4:0] A_TRI_LIN = 5'h08;
  localparam logic [4:0] A_TRI_LO = 5'h0A;
  localparam logic [4:0] A_TRI_HI = 5'h0B;
  localparam logic [4:0] A_NOI_CTL = 5'h0C;
  localparam logic [4:0] A_NOI_PER = 5'h0E;
  localparam logic [4:0] A_NOI_LEN = 5'h0F;
  localparam logic [4:0] A_DMC_LVL = 5'h11;
  localparam logic [4:0] A_STATUS = 5'h15;
  localparam logic [4:0] A_FRAME  = 5'h17;

  localparam logic [10:0] PERIOD_MAX = 11'h7FF;
  localparam logic [14:0] STEP_Q1 = 15'd3729;
  localparam logic [14:0] STEP_H1 = 15'd7457;
  localparam logic [14:0] STEP_Q3 = 15'd11186;
  localparam logic [14:0] STEP_H4 = 15'd14915;
  localparam logic [14:0] STEP_H5 = 15'd18641;
  localparam logic [3:0]  ENV_TOP = 4'd15;

  typedef struct packed {
    logic       start;
    logic [3:0] decay;
    logic [3:0] divider;
  } env_t;

  typedef struct packed {
    logic       enable;
    logic [2:0] period;
    logic       negate;
    logic [2:0] shift;
    logic       reload;
    logic [2:0] divider;
  } sweep_t;

  // op sits in the lowest bits
  typedef struct packed {
    logic [7:0] write_data;
    logic [4:0] reg_addr;
    logic [1:0] op;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] p1;
    logic [3:0] p2;
    logic [3:0] tri_l;
    logic [3:0] noi;
    logic [6:0] dmc;
    logic       irq;
  } res_t;

  function automatic logic [7:0] len_lookup(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0: r = 8'd10;   5'd1: r = 8'd254;  5'd2: r = 8'd20;   5'd3: r = 8'd2;
      5'd4: r = 8'd40;   5'd5: r = 8'd4;    5'd6: r = 8'd80;   5'd7: r = 8'd6;
      5'd8: r = 8'd160;  5'd9: r = 8'd8;    5'd10: r = 8'd60;  5'd11: r = 8'd10;
      5'd12: r = 8'd14;  5'd13: r = 8'd12;  5'd14: r = 8'd26;  5'd15: r = 8'd14;
      5'd16: r = 8'd12;  5'd17: r = 8'd16;  5'd18: r = 8'd24;  5'd19: r = 8'd18;
      5'd20: r = 8'd48;  5'd21: r = 8'd20;  5'd22: r = 8'd96;  5'd23: r = 8'd22;
      5'd24: r = 8'd192; 5'd25: r = 8'd24;  5'd26: r = 8'd72;  5'd27: r = 8'd26;
      5'd28: r = 8'd16;  5'd29: r = 8'd28;  5'd30: r = 8'd32;  default: r = 8'd30;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] noise_lookup(input logic [3:0] i);
    logic [11:0] r;
    case (i)
      4'd0: r = 12'd4;     4'd1: r = 12'd8;     4'd2: r = 12'd16;   4'd3: r = 12'd32;
      4'd4: r = 12'd64;    4'd5: r = 12'd96;    4'd6: r = 12'd128;  4'd7: r = 12'd160;
      4'd8: r = 12'd202;   4'd9: r = 12'd254;   4'd10: r = 12'd380; 4'd11: r = 12'd508;
      4'd12: r = 12'd762;  4'd13: r = 12'd1016; 4'd14: r = 12'd2034;
      default: r = 12'd4068;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] duty_lookup(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0: r = 8'h02;
      2'd1: r = 8'h06;
      2'd2: r = 8'h1E;
      default: r = 8'hF9;
    endcase
    return r;
  endfunction

  // sweep target, clamped at zero; bit 11 flags overflow past 0x7ff
  function automatic logic [11:0] sweep_tgt(input logic [10:0] p, input sweep_t s,
                                            input logic ones);
    logic [11:0] d;
    logic [12:0] t;
    d = {1'b0, p >> s.shift};
    if (s.negate) begin
      t = {2'b0, p} - {1'b0, d} - {12'b0, ones};
      if (t[12]) t = 13'd0;
    end else begin
      t = {2'b0, p} + {1'b0, d};
    end
    return t[11:0];
  endfunction

  function automatic env_t env_clock(input env_t e, input logic [3:0] vol,
                                     input logic lp);
    env_t r;
    r = e;
    if (e.start) begin
      r.start = 1'b0;
      r.decay = ENV_TOP;
      r.divider = vol;
    end else if (e.divider == 4'd0) begin
      r.divider = vol;
      if (e.decay != 4'd0) r.decay = e.decay - 4'd1;
      else if (lp) r.decay = ENV_TOP;
    end else begin
      r.divider = e.divider - 4'd1;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/sound_channels_frame_sequencer.sv @@
// ---------------------------------------------------------------------------
// sound_channels_frame_sequencer
// two pulse, triangle and noise channels with frame sequencer; unless the sink stalls, one request
// per cycle
// ---------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                          | tuser
// in_     | in  | op[1:0] reg_addr[6:2] write_data[14:7]       | -
// out_    | out | read_data, pulse1, pulse2, tri, noise, dmc   | irq_pending
//
// every request is applied in the cycle it is accepted; the result lands in
// a single output register in the cycle after acceptance
// one request per cycle sustained; in_tready drops only while a result waits
// and the sink stalls (in_tready = !out_tvalid | out_tready)
// synchronous active-low reset clears all channel state; lfsr resets to one
`timescale 1ns / 1ps
`default_nettype none
module sound_channels_frame_sequencer
  import scfs_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // op[1:0], reg_addr[6:2], write_data[14:7]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // read_data[7:0], p1[11:8], p2[15:12],
                                  // tri[19:16], noise[23:20], dmc[30:24]
  output logic        out_tuser   // irq_pending
);
  // channel state
  logic [10:0] pper_r [2], pper_nxt [2];
  logic [10:0] ptim_r [2], ptim_nxt [2];
  logic [2:0]  pstep_r [2], pstep_nxt [2];
  logic [7:0]  pctl_r [2], pctl_nxt [2];
  env_t        penv_r [2], penv_nxt [2];
  sweep_t      pswp_r [2], pswp_nxt [2];
  logic [7:0]  plen_r [2], plen_nxt [2];
  logic [10:0] tper_r, tper_nxt, ttim_r, ttim_nxt;
  logic [4:0]  tstep_r, tstep_nxt;
  logic [6:0]  tload_r, tload_nxt, tcnt_r, tcnt_nxt;
  logic        treload_r, treload_nxt, thalt_r, thalt_nxt;
  logic [7:0]  tlen_r, tlen_nxt;
  logic [11:0] nper_r, nper_nxt, ntim_r, ntim_nxt;
  logic [14:0] lfsr_r, lfsr_nxt;
  logic        nmode_r, nmode_nxt, nhalt_r, nhalt_nxt, nconst_r, nconst_nxt;
  logic [3:0]  nvol_r, nvol_nxt;
  env_t        nenv_r, nenv_nxt;
  logic [7:0]  nlen_r, nlen_nxt;
  logic [4:0]  en_r, en_nxt;
  logic [6:0]  dmc_r, dmc_nxt;
  logic [14:0] fcnt_r, fcnt_nxt;
  logic        fmode_r, fmode_nxt, finh_r, finh_nxt, firq_r, firq_nxt;
  logic        par_r, par_nxt;
  logic [7:0]  rd_nxt;
  res_t        res_r, res_nxt;
  logic        ovalid_r;

  req_t req;
  logic acc;
  assign req = req_t'(in_tdata[14:0]);
  assign in_tready = !ovalid_r || out_tready;
  assign acc = in_tvalid && in_tready;

  always_comb begin
    logic qf, hf;
    logic [14:0] fc;
    logic [11:0] tg;
    logic [7:0] v;
    logic [11:0] t0;
    logic [11:0] t1;
    logic [7:0]  dt;
    logic        fb;
    for (int c = 0; c < 2; c++) begin
      pper_nxt[c] = pper_r[c]; ptim_nxt[c] = ptim_r[c]; pstep_nxt[c] = pstep_r[c];
      pctl_nxt[c] = pctl_r[c]; penv_nxt[c] = penv_r[c]; pswp_nxt[c] = pswp_r[c];
      plen_nxt[c] = plen_r[c];
    end
    tper_nxt = tper_r; ttim_nxt = ttim_r; tstep_nxt = tstep_r; tload_nxt = tload_r;
    tcnt_nxt = tcnt_r; treload_nxt = treload_r; thalt_nxt = thalt_r; tlen_nxt = tlen_r;
    nper_nxt = nper_r; ntim_nxt = ntim_r; lfsr_nxt = lfsr_r; nmode_nxt = nmode_r;
    nhalt_nxt = nhalt_r; nconst_nxt = nconst_r; nvol_nxt = nvol_r; nenv_nxt = nenv_r;
    nlen_nxt = nlen_r; en_nxt = en_r; dmc_nxt = dmc_r; fcnt_nxt = fcnt_r;
    fmode_nxt = fmode_r; finh_nxt = finh_r; firq_nxt = firq_r; par_nxt = par_r;
    rd_nxt = 8'd0;
    qf = 1'b0; hf = 1'b0;
    v = req.write_data;
    fc = fcnt_r + 15'd1;
    fb = 1'b0;
    case (req.op)
      OP_WRITE: begin
        if (req.reg_addr < 5'd8) begin
          for (int c = 0; c < 2; c++) begin
            if (req.reg_addr[2] == c[0]) begin
              case (req.reg_addr[1:0])
                2'd0: pctl_nxt[c] = v;
                2'd1: pswp_nxt[c] = '{enable: v[7], period: v[6:4], negate: v[3],
                                      shift: v[2:0], reload: 1'b1,
                                      divider: pswp_r[c].divider};
                2'd2: pper_nxt[c] = {pper_r[c][10:8], v};
                default: begin
                  pper_nxt[c] = {v[2:0], pper_r[c][7:0]};
                  if (en_r[c]) plen_nxt[c] = len_lookup(v[7:3]);
                  penv_nxt[c].start = 1'b1;
                  pstep_nxt[c] = 3'd0;
                end
              endcase
            end
          end
        end else begin
          case (req.reg_addr)
            A_TRI_LIN: begin thalt_nxt = v[7]; tload_nxt = v[6:0]; end
            A_TRI_LO:  tper_nxt = {tper_r[10:8], v};
            A_TRI_HI: begin
              tper_nxt = {v[2:0], tper_r[7:0]};
              if (en_r[2]) tlen_nxt = len_lookup(v[7:3]);
              treload_nxt = 1'b1;
            end
            A_NOI_CTL: begin nhalt_nxt = v[5]; nconst_nxt = v[4]; nvol_nxt = v[3:0]; end
            A_NOI_PER: begin nmode_nxt = v[7]; nper_nxt = noise_lookup(v[3:0]); end
            A_NOI_LEN: begin
              if (en_r[3]) nlen_nxt = len_lookup(v[7:3]);
              nenv_nxt.start = 1'b1;
            end
            A_DMC_LVL: dmc_nxt = v[6:0];
            A_STATUS: begin
              en_nxt = v[4:0];
              if (!v[0]) plen_nxt[0] = 8'd0;
              if (!v[1]) plen_nxt[1] = 8'd0;
              if (!v[2]) tlen_nxt = 8'd0;
              if (!v[3]) nlen_nxt = 8'd0;
            end
            A_FRAME: begin
              fmode_nxt = v[7]; finh_nxt = v[6];
              if (v[6]) firq_nxt = 1'b0;
              fcnt_nxt = 15'd0;
              qf = v[7]; hf = v[7];
            end
            default: ;
          endcase
        end
      end
      OP_READ: begin
        if (req.reg_addr == A_STATUS) begin
          rd_nxt = {1'b0, firq_r, 2'b00, nlen_r != 8'd0, tlen_r != 8'd0,
                    plen_r[1] != 8'd0, plen_r[0] != 8'd0};
          firq_nxt = 1'b0;
        end
      end
      OP_TICK: begin
        if (ttim_r == 11'd0) begin
          ttim_nxt = tper_r;
          if (tlen_r != 8'd0 && tcnt_r != 7'd0) tstep_nxt = tstep_r + 5'd1;
        end else ttim_nxt = ttim_r - 11'd1;
        par_nxt = !par_r;
        if (!par_r) begin
          for (int c = 0; c < 2; c++) begin
            if (ptim_r[c] == 11'd0) begin
              ptim_nxt[c] = pper_r[c];
              pstep_nxt[c] = pstep_r[c] + 3'd1;
            end else ptim_nxt[c] = ptim_r[c] - 11'd1;
          end
          if (ntim_r == 12'd0) begin
            ntim_nxt = nper_r;
            fb = lfsr_r[0] ^ (nmode_r ? lfsr_r[6] : lfsr_r[1]);
            lfsr_nxt = {fb, lfsr_r[14:1]};
          end else ntim_nxt = ntim_r - 12'd1;
          fcnt_nxt = fc;
          if (fc == STEP_Q1 || fc == STEP_Q3) qf = 1'b1;
          else if (fc == STEP_H1) begin qf = 1'b1; hf = 1'b1; end
          else if (!fmode_r && fc == STEP_H4) begin
            qf = 1'b1; hf = 1'b1;
            if (!finh_r) firq_nxt = 1'b1;
            fcnt_nxt = 15'd0;
          end else if (fmode_r && fc == STEP_H5) begin
            qf = 1'b1; hf = 1'b1; fcnt_nxt = 15'd0;
          end
        end
      end
      default: ;
    endcase

    // quarter frame: envelopes and linear counter (from tick frame steps and frame writes with bit 7 set)
    if (qf) begin
      for (int c = 0; c < 2; c++)
        penv_nxt[c] = env_clock(penv_nxt[c], pctl_nxt[c][3:0], pctl_nxt[c][5]);
      if (treload_nxt) tcnt_nxt = tload_nxt;
      else if (tcnt_nxt != 7'd0) tcnt_nxt = tcnt_nxt - 7'd1;
      if (!thalt_nxt) treload_nxt = 1'b0;
      nenv_nxt = env_clock(nenv_nxt, nvol_nxt, nhalt_nxt);
    end
    // half frame: length counters and sweeps
    if (hf) begin
      for (int c = 0; c < 2; c++) begin
        if (!pctl_nxt[c][5] && plen_nxt[c] != 8'd0) plen_nxt[c] = plen_nxt[c] - 8'd1;
        tg = sweep_tgt(pper_nxt[c], pswp_nxt[c], c == 0);
        if (pswp_nxt[c].divider == 3'd0 && pswp_nxt[c].enable &&
            pswp_nxt[c].shift != 3'd0 && pper_nxt[c] >= 11'd8 && !tg[11])
          pper_nxt[c] = tg[10:0];
        if (pswp_nxt[c].divider == 3'd0 || pswp_nxt[c].reload) begin
          pswp_nxt[c].divider = pswp_nxt[c].period;
          pswp_nxt[c].reload = 1'b0;
        end else pswp_nxt[c].divider = pswp_nxt[c].divider - 3'd1;
      end
      if (!thalt_nxt && tlen_nxt != 8'd0) tlen_nxt = tlen_nxt - 8'd1;
      if (!nhalt_nxt && nlen_nxt != 8'd0) nlen_nxt = nlen_nxt - 8'd1;
    end

    // levels after the step
    t0 = sweep_tgt(pper_nxt[0], pswp_nxt[0], 1'b1);
    t1 = sweep_tgt(pper_nxt[1], pswp_nxt[1], 1'b0);
    res_nxt = '0;
    res_nxt.read_data = rd_nxt;
    dt = duty_lookup(pctl_nxt[0][7:6]);
    if (en_nxt[0] && plen_nxt[0] != 8'd0 && dt[pstep_nxt[0]] &&
        pper_nxt[0] >= 11'd8 && !t0[11])
      res_nxt.p1 = pctl_nxt[0][4] ? pctl_nxt[0][3:0] : penv_nxt[0].decay;
    dt = duty_lookup(pctl_nxt[1][7:6]);
    if (en_nxt[1] && plen_nxt[1] != 8'd0 && dt[pstep_nxt[1]] &&
        pper_nxt[1] >= 11'd8 && !t1[11])
      res_nxt.p2 = pctl_nxt[1][4] ? pctl_nxt[1][3:0] : penv_nxt[1].decay;
    if (en_nxt[2] && tlen_nxt != 8'd0 && tcnt_nxt != 7'd0)
      res_nxt.tri_l = (tper_nxt < 11'd2) ? 4'd7 :
                      (tstep_nxt[4] ? tstep_nxt[3:0] : ~tstep_nxt[3:0]);
    if (en_nxt[3] && nlen_nxt != 8'd0 && !lfsr_nxt[0])
      res_nxt.noi = nconst_nxt ? nvol_nxt : nenv_nxt.decay;
    res_nxt.dmc = dmc_nxt;
    res_nxt.irq = firq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 2; c++) begin
        pper_r[c] <= '0; ptim_r[c] <= '0; pstep_r[c] <= '0; pctl_r[c] <= '0;
        penv_r[c] <= '0; pswp_r[c] <= '0; plen_r[c] <= '0;
      end
      tper_r <= '0; ttim_r <= '0; tstep_r <= '0; tload_r <= '0; tcnt_r <= '0;
      treload_r <= 1'b0; thalt_r <= 1'b0; tlen_r <= '0;
      nper_r <= '0; ntim_r <= '0; lfsr_r <= 15'd1; nmode_r <= 1'b0; nhalt_r <= 1'b0;
      nconst_r <= 1'b0; nvol_r <= '0; nenv_r <= '0; nlen_r <= '0;
      en_r <= '0; dmc_r <= '0; fcnt_r <= '0; fmode_r <= 1'b0; finh_r <= 1'b0;
      firq_r <= 1'b0; par_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      if (acc) begin
        pper_r <= pper_nxt; ptim_r <= ptim_nxt; pstep_r <= pstep_nxt;
        pctl_r <= pctl_nxt; penv_r <= penv_nxt; pswp_r <= pswp_nxt; plen_r <= plen_nxt;
        tper_r <= tper_nxt; ttim_r <= ttim_nxt; tstep_r <= tstep_nxt;
        tload_r <= tload_nxt; tcnt_r <= tcnt_nxt; treload_r <= treload_nxt;
        thalt_r <= thalt_nxt; tlen_r <= tlen_nxt;
        nper_r <= nper_nxt; ntim_r <= ntim_nxt; lfsr_r <= lfsr_nxt;
        nmode_r <= nmode_nxt; nhalt_r <= nhalt_nxt; nconst_r <= nconst_nxt;
        nvol_r <= nvol_nxt; nenv_r <= nenv_nxt; nlen_r <= nlen_nxt;
        en_r <= en_nxt; dmc_r <= dmc_nxt; fcnt_r <= fcnt_nxt;
        fmode_r <= fmode_nxt; finh_r <= finh_nxt; firq_r <= firq_nxt; par_r <= par_nxt;
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only with an accepted request
  always_ff @(posedge clk) begin
    if (acc) res_r <= res_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {1'b0, res_r.dmc, res_r.noi, res_r.tri_l, res_r.p2, res_r.p1,
                      res_r.read_data};
  assign out_tuser = res_r.irq;
endmodule
`default_nettype wire

@@ rtl/core/scfs_checker.sv @@
// ---------------------------------------------------------------------------
// scfs_checker
// port-level checks on the sound channel frame sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module scfs_checker
  import scfs_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [15:0] in_tdata,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire        out_tuser
);
  // each accepted request yields a result next cycle
  `ASSERT_NEXT(a_result, clk, rst_n, in_tvalid && in_tready, out_tvalid)
  // input side opens whenever the output is free
  `ASSERT_IMPL(a_ready, clk, rst_n, !out_tvalid || out_tready, in_tready)
  // a status read clears the irq flag in its result
  `ASSERT_NEXT(a_irqclr, clk, rst_n,
    in_tvalid && in_tready && in_tdata[1:0] == OP_READ && in_tdata[6:2] == A_STATUS,
    !out_tuser)
  // read data only on reads
  `ASSERT_NEXT(a_rdzero, clk, rst_n,
    in_tvalid && in_tready && in_tdata[1:0] != OP_READ, out_tdata[7:0] == 8'd0)
  // stalled result holds
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))
endmodule

bind sound_channels_frame_sequencer scfs_checker u_scfs_checker (.*);
`default_nettype wire
